/* sv/msss_pkg.sv */
package msss_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_BAD_STACK = 2'd3
  } status_e;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

endpackage

/* sv/msss_ram.sv */
module msss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/multi_stack_shared_store.sv */
// Several LIFO stacks share one pool of SLOTS value slots. Each request beat is a push of
// a 32-bit value onto a stack or a pop from it; every request gives exactly one result beat
// with a status (ok, overflow, underflow, bad stack number) and, for a successful pop, the
// value. Values and slot links live in two synchronous RAMs with registered reads; the stack
// tops and the free-list head sit in flops. The accept cycle reads the link and value RAMs;
// the execute state then writes the link back and updates the heads once the result
// register is free. A request is taken only in the idle state, after the previous one.
// The result register lets the next request in while the previous result still waits.
// The link RAM needs no clearing pass after reset: a high-water mark marks slots never
// handed out, whose link is implied as the following slot.
module multi_stack_shared_store
  import msss_pkg::*;
#(
  parameter int NUM_STACKS = 4,
  parameter int SLOTS      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  logic [3:0]  s_axis_tuser,   // [0] kind, [3:1] stack_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] pop_value
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int AW = $clog2(SLOTS);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int HW = $clog2(SLOTS + 1);

  typedef struct packed {
    logic          valid;
    logic [AW-1:0] idx;
  } ptr_t;

  state_e  state_q, state_d;
  logic    kind_q;
  logic    sel_ok_q;
  logic [SW-1:0] sidx_q;
  logic [AW-1:0] slot_q;
  ptr_t    stack_head_q [NUM_STACKS];
  ptr_t    free_head_q;
  logic [HW-1:0] hw_q;
  logic    out_valid_q;
  status_e out_status_q, status_d;
  logic [31:0] out_value_q;

  logic          in_fire, in_kind, in_sel_ok, data_we;
  logic [2:0]    in_sel;
  logic [SW-1:0] in_sidx;
  ptr_t          in_head;
  logic [AW-1:0] in_slot;

  logic          exec_go, op_ok, fresh;
  ptr_t          head_cur, link_rd, fresh_link, link_wdata;
  logic [AW:0]   link_rdata;
  logic [31:0]   data_rdata;
  logic [HW-1:0] nxt;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_kind   = s_axis_tuser[0];
  assign in_sel    = s_axis_tuser[3:1];
  assign in_sel_ok = ({1'b0, in_sel} < 4'(NUM_STACKS));
  assign in_sidx   = in_sel_ok ? in_sel[SW-1:0] : '0;
  assign in_head   = stack_head_q[in_sidx];
  assign in_slot   = (in_kind == KIND_POP) ? in_head.idx : free_head_q.idx;
  // the value goes in at accept, the slot is free and stays ours until write-back
  assign data_we   = in_fire && in_sel_ok && (in_kind == KIND_PUSH) && free_head_q.valid;

  assign exec_go  = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready);
  assign head_cur = stack_head_q[sidx_q];

  always_comb begin
    if (!sel_ok_q) begin
      status_d = STATUS_BAD_STACK;
    end else if (kind_q == KIND_PUSH) begin
      status_d = free_head_q.valid ? STATUS_OK : STATUS_OVERFLOW;
    end else begin
      status_d = head_cur.valid ? STATUS_OK : STATUS_UNDERFLOW;
    end
  end

  assign op_ok = (status_d == STATUS_OK);

  // slots at or above the high-water mark were never linked: they point to the next one
  assign fresh            = (kind_q == KIND_PUSH) && (HW'(slot_q) >= hw_q);
  assign nxt              = HW'(slot_q) + HW'(1);
  assign fresh_link.valid = (nxt < HW'(SLOTS));
  assign fresh_link.idx   = nxt[AW-1:0];
  assign link_rd          = fresh ? fresh_link : ptr_t'(link_rdata);
  assign link_wdata       = (kind_q == KIND_PUSH) ? head_cur : free_head_q;

  msss_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (in_slot),
    .wdata_i (s_axis_tdata),
    .re_i    (in_fire),
    .raddr_i (in_slot),
    .rdata_o (data_rdata)
  );

  msss_ram #(
    .WIDTH (AW + 1),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (exec_go && op_ok),
    .waddr_i (slot_q),
    .wdata_i (link_wdata),
    .re_i    (in_fire),
    .raddr_i (in_slot),
    .rdata_o (link_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q   <= in_kind;
      sel_ok_q <= in_sel_ok;
      sidx_q   <= in_sidx;
      slot_q   <= in_slot;
    end
    if (exec_go) begin
      out_status_q <= status_d;
      out_value_q  <= (op_ok && (kind_q == KIND_POP)) ? data_rdata : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      free_head_q.valid <= 1'b1;
      free_head_q.idx   <= '0;
      hw_q              <= '0;
      out_valid_q       <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_head_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (exec_go && op_ok) begin
        if (kind_q == KIND_PUSH) begin
          free_head_q                <= link_rd;
          stack_head_q[sidx_q].valid <= 1'b1;
          stack_head_q[sidx_q].idx   <= slot_q;
          if (fresh) hw_q <= hw_q + HW'(1);
        end else begin
          stack_head_q[sidx_q] <= link_rd;
          free_head_q.valid    <= 1'b1;
          free_head_q.idx      <= slot_q;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_status_q;

`ifndef SYNTH
  a_hw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= HW'(SLOTS))
    else $error("high-water mark past the slot count");

  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && sel_ok_q && (kind_q == KIND_PUSH) && !free_head_q.valid)
    |=> (m_axis_tuser == STATUS_OVERFLOW))
    else $error("push on empty free list not reported as overflow");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_go && op_ok && (kind_q == KIND_POP)) |=> free_head_q.valid)
    else $error("popped slot not returned to free list");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_EXEC))
    else $error("result beat without a request in write-back");
`endif

endmodule

/* test/multi_stack_shared_store_checker.sv */
`timescale 1ns / 100ps

module multi_stack_shared_store_checker
  import msss_pkg::*;
#(
  parameter int NUM_STACKS = 4,
  parameter int SLOTS      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  logic [3:0]  s_axis_tuser,   // [0] kind, [3:1] stack_select
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] pop_value
  input  logic [1:0]  m_axis_tuser,   // [1:0] status
  output int          fail_count_o,
  output int          backlog_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic          live;
    logic [IW-1:0] slot;
  } slot_ptr_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] value;
  } stack_reply_t;

  logic [31:0]  slot_value [SLOTS];
  slot_ptr_t    slot_next  [SLOTS];
  slot_ptr_t    top_of     [NUM_STACKS];
  slot_ptr_t    free_top;
  stack_reply_t replies_due [$];
  stack_reply_t oldest_reply;

  function automatic void clear_stacks();
    for (int i = 0; i < SLOTS; i++) begin
      slot_value[i] = '0;
      slot_next[i]  = '{live: (i + 1 < SLOTS), slot: IW'(i + 1)};
    end
    for (int i = 0; i < NUM_STACKS; i++) begin
      top_of[i] = '0;
    end
    free_top = '{live: 1'b1, slot: '0};
  endfunction

  // applies one request to the shadow stacks and returns the reply it should give
  function automatic stack_reply_t run_request(logic kind, logic [2:0] sel,
                                               logic [31:0] value);
    stack_reply_t  reply;
    logic [IW-1:0] s;
    reply.status = STATUS_OK;
    reply.value  = '0;
    if (sel >= NUM_STACKS) begin
      reply.status = STATUS_BAD_STACK;
    end else if (kind == KIND_PUSH) begin
      if (!free_top.live) begin
        reply.status = STATUS_OVERFLOW;
      end else begin
        s             = free_top.slot;
        free_top      = slot_next[s];
        slot_value[s] = value;
        slot_next[s]  = top_of[sel];
        top_of[sel]   = '{live: 1'b1, slot: s};
      end
    end else begin
      if (!top_of[sel].live) begin
        reply.status = STATUS_UNDERFLOW;
      end else begin
        s            = top_of[sel].slot;
        top_of[sel]  = slot_next[s];
        slot_next[s] = free_top;
        free_top     = '{live: 1'b1, slot: s};
        reply.value  = slot_value[s];
      end
    end
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_stacks();
      replies_due.delete();
      fail_count_o = 0;
      backlog_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (replies_due.size() == 0) begin
          $error("result beat with nothing pending: status %0d pop_value %h",
                 m_axis_tuser, m_axis_tdata);
          fail_count_o++;
        end else begin
          oldest_reply = replies_due.pop_front();
          if (m_axis_tuser !== oldest_reply.status) begin
            $error("status mismatch: expected %0d actual %0d",
                   oldest_reply.status, m_axis_tuser);
            fail_count_o++;
          end
          if (m_axis_tdata !== oldest_reply.value) begin
            $error("pop_value mismatch: expected %h actual %h",
                   oldest_reply.value, m_axis_tdata);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        replies_due.push_back(run_request(s_axis_tuser[0], s_axis_tuser[3:1], s_axis_tdata));
      end
      backlog_o = replies_due.size();
    end
  end

endmodule

/* test/multi_stack_shared_store_test.sv */
`timescale 1ns / 100ps

module multi_stack_shared_store_test;
  import msss_pkg::*;

  localparam int NUM_STACKS = 4;
  localparam int SLOTS      = 8;
  localparam int RANDOM_REQUESTS = 600;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] push_value
  logic [3:0]  s_axis_tuser;   // [0] kind, [3:1] stack_select
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] pop_value
  logic [1:0]  m_axis_tuser;   // [1:0] status
  int          fail_count;
  int          backlog;

  multi_stack_shared_store #(
    .NUM_STACKS(NUM_STACKS),
    .SLOTS     (SLOTS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  multi_stack_shared_store_checker #(
    .NUM_STACKS(NUM_STACKS),
    .SLOTS     (SLOTS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .backlog_o    (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("multi_stack_shared_store verification failed");
    $finish;
  end

  // offer one request beat, with random idle cycles ahead of it unless no_gaps is set
  task automatic send_request(input logic kind, input logic [2:0] sel,
                              input logic [31:0] value, input bit no_gaps);
    while (!no_gaps && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= {sel, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold-off to back up the block, then a calm stretch
  initial begin : drain
    int cycle;
    cycle = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle >= 600 && cycle < 700) begin
        m_axis_tready <= 1'b0;
      end else if (cycle >= 1000 && cycle < 1400) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 28);
      end
    end
  end

  initial begin : stimulus
    int          lean;
    int          pop_pct;
    logic        kind;
    logic [2:0]  sel;
    logic [31:0] value;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // empty stack, bad stack numbers on both operations
    send_request(KIND_POP,  3'd0, 32'h0000_0000, 1'b0);
    send_request(KIND_PUSH, 3'd4, 32'hdead_beef, 1'b0);
    send_request(KIND_POP,  3'd7, 32'hffff_ffff, 1'b0);
    // value extremes on every stack
    send_request(KIND_PUSH, 3'd0, 32'h8000_0000, 1'b0);
    send_request(KIND_PUSH, 3'd1, 32'h7fff_ffff, 1'b0);
    send_request(KIND_PUSH, 3'd2, 32'h0000_0000, 1'b0);
    send_request(KIND_PUSH, 3'd3, 32'hffff_ffff, 1'b0);
    // use up the pool, then overflow and a bad stack while full
    for (int i = 0; i < SLOTS - NUM_STACKS; i++) begin
      send_request(KIND_PUSH, 3'd3, 32'h1234_5670 + i, 1'b0);
    end
    send_request(KIND_PUSH, 3'd0, 32'h5555_5555, 1'b0);
    send_request(KIND_PUSH, 3'd5, 32'haaaa_aaaa, 1'b0);
    // drain stack 3 past empty, then the rest
    for (int i = 0; i <= SLOTS - NUM_STACKS + 1; i++) begin
      send_request(KIND_POP, 3'd3, $urandom, 1'b0);
    end
    send_request(KIND_POP, 3'd0, 32'h0000_0000, 1'b0);
    send_request(KIND_POP, 3'd1, 32'h0000_0000, 1'b0);
    send_request(KIND_POP, 3'd2, 32'h0000_0000, 1'b0);

    // runs that lean toward filling, draining or neither, so full and empty come up often
    lean = 2;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) lean = $urandom_range(2);
      pop_pct = (lean == 0) ? 25 : (lean == 1) ? 75 : 50;
      kind = ($urandom_range(99) < pop_pct) ? KIND_POP : KIND_PUSH;
      if ($urandom_range(99) < 12) begin
        sel = 3'($urandom_range(7, NUM_STACKS));
      end else begin
        sel = 3'($urandom_range(NUM_STACKS - 1));
      end
      case ($urandom_range(9))
        0: value = 32'h8000_0000;
        1: value = 32'h7fff_ffff;
        2: value = 32'h0000_0000;
        3: value = 32'hffff_ffff;
        default: value = $urandom;
      endcase
      send_request(kind, sel, value, (n >= 250 && n < 350));
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("multi_stack_shared_store verification clean");
    end else begin
      $display("multi_stack_shared_store verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/msss_pkg.sv
sv/msss_ram.sv
sv/multi_stack_shared_store.sv
test/multi_stack_shared_store_checker.sv
test/multi_stack_shared_store_test.sv
